// File: hw/rtl/tlru_pkg.sv
// shared types and constants of the two-way lru tag lookup
// no dependencies

package tlru_pkg;

  localparam int unsigned SET_COUNT = 4;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WAYS      = 2;
  localparam int unsigned SET_W     = $clog2(SET_COUNT);
  localparam int unsigned TAG_W     = ADDR_W - SET_W;
  localparam int unsigned ROW_W     = WAYS * TAG_W;

  localparam logic WAY0 = 1'b0;
  localparam logic WAY1 = 1'b1;

  typedef logic [TAG_W-1:0]            tag_t;
  typedef logic [SET_W-1:0]            set_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  row_t;
  typedef logic [WAYS-1:0]             way_valid_t;

  typedef struct packed {
    logic hit;
    logic way;
  } lookup_t;

endpackage

// File: hw/rtl/tlru_if.sv
// handshake channels of the tag lookup: address items in, hit/way items out
// depends on tlru_pkg

interface tlru_addr_if;
  logic                        valid;
  logic                        ready;
  logic [tlru_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface tlru_res_if;
  logic valid;
  logic ready;
  logic hit;
  logic way_used;

  modport source (output valid, output hit, output way_used, input ready);
  modport sink   (input valid, input hit, input way_used, output ready);
endinterface

// File: hw/rtl/two_way_lru_cache_tag_lookup_unit.sv
// top level of the two-way set-associative tag lookup with one-bit lru
// depends on tlru_pkg, tlru_if, tlru_ram, tlru_way_sel

// For each address item, the set row (both way tags) is read from the tag
// ram in the cycle the item is accepted, into the ram's read register, and
// busy is set. While busy, both ways are compared, the victim is chosen, the
// row is written back on a miss and the result item is loaded into the output
// register. No new address item is taken while busy, so the block finishes
// each item before it accepts the next. The output register keeps a finished
// result while a new item is read; if it is still full when the compare is
// due, the lookup waits in place. Valid bits and lru bits live in flip-flops
// and are cleared by reset at once, so there is no clearing pass; tag ram
// contents are undefined until written and are only used behind a set valid
// bit. The low set-index bits of the address pick the set and the remaining
// bits form the tag.

module two_way_lru_cache_tag_lookup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlru_addr_if.sink   in_i,
  tlru_res_if.source  out_o
);

  // lookup in flight: ram row has been read, compare pending
  logic             busy_q, busy_d;
  tlru_pkg::tag_t   req_tag_q;
  tlru_pkg::set_t   req_set_q;

  // per-set state kept in flops
  tlru_pkg::way_valid_t [tlru_pkg::SET_COUNT-1:0] valid_q;
  logic [tlru_pkg::SET_COUNT-1:0]                 lru_q;

  // output register
  logic out_valid_q, out_valid_d;
  logic out_hit_q;
  logic out_way_q;

  logic              accept;
  logic              done;
  tlru_pkg::row_t    rd_row;
  tlru_pkg::row_t    wr_row;
  tlru_pkg::lookup_t res;
  logic [tlru_pkg::ROW_W-1:0] rd_data;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  // compare completes once the output register has room
  assign done       = busy_q && (!out_valid_q || out_o.ready);

  // tag ram: one row per set holding both way tags
  tlru_ram #(
    .DEPTH (tlru_pkg::SET_COUNT),
    .WIDTH (tlru_pkg::ROW_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (done && !res.hit),
    .waddr_i (req_set_q),
    .wdata_i (wr_row),
    .re_i    (accept),
    .raddr_i (in_i.address[tlru_pkg::SET_W-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_row = tlru_pkg::row_t'(rd_data);

  tlru_way_sel u_way_sel (
    .tag_i   (req_tag_q),
    .row_i   (rd_row),
    .valid_i (valid_q[req_set_q]),
    .lru_i   (lru_q[req_set_q]),
    .res_o   (res)
  );

  // read-modify-write: replace only the victim's tag in the row
  always_comb begin
    wr_row          = rd_row;
    wr_row[res.way] = req_tag_q;
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      lru_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (done) begin
        // the used way becomes most recent, the other one lru
        lru_q[req_set_q] <= !res.way;
        if (!res.hit) begin
          valid_q[req_set_q][res.way] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_set_q <= in_i.address[tlru_pkg::SET_W-1:0];
      req_tag_q <= in_i.address[tlru_pkg::ADDR_W-1:tlru_pkg::SET_W];
    end
    if (done) begin
      out_hit_q <= res.hit;
      out_way_q <= res.way;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit      = out_hit_q;
  assign out_o.way_used = out_way_q;

endmodule

// File: hw/rtl/tlru_ram.sv
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies

module tlru_ram #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tlru_way_sel.sv
// way compare and victim choice for one set of the two-way tag store
// depends on tlru_pkg

module tlru_way_sel (
  input  tlru_pkg::tag_t       tag_i,
  input  tlru_pkg::row_t       row_i,
  input  tlru_pkg::way_valid_t valid_i,
  input  logic                 lru_i,
  output tlru_pkg::lookup_t    res_o
);

  logic hit0;
  logic hit1;

  assign hit0 = valid_i[tlru_pkg::WAY0] && (row_i[tlru_pkg::WAY0] == tag_i);
  assign hit1 = valid_i[tlru_pkg::WAY1] && (row_i[tlru_pkg::WAY1] == tag_i);

  always_comb begin
    res_o = '0;
    priority if (hit0) begin
      res_o.hit = 1'b1;
      res_o.way = tlru_pkg::WAY0;
    end else if (hit1) begin
      res_o.hit = 1'b1;
      res_o.way = tlru_pkg::WAY1;
    end else if (!valid_i[tlru_pkg::WAY0]) begin
      res_o.way = tlru_pkg::WAY0;
    end else if (!valid_i[tlru_pkg::WAY1]) begin
      res_o.way = tlru_pkg::WAY1;
    end else begin
      // both valid, replace least recently used
      res_o.way = lru_i;
    end
  end

endmodule
